>>> sv/uart_register_model_assert.svh
// ----------------------------------------------------------------------------
// uart_register_model_assert.svh
// Assertion macros for the UART register block, clocked on aclk, held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_MODEL_ASSERT_SVH
`define UART_REGISTER_MODEL_ASSERT_SVH

// same-cycle implication
`define URM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define URM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/urm_pkg.sv
// ----------------------------------------------------------------------------
// urm_pkg
// Types, codes and decode functions shared by the UART register block.
// ----------------------------------------------------------------------------
`default_nettype none

package urm_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FORCE_DCD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INT_MASK  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INT_ACK   = 2'd2;

    typedef enum logic [1:0] {
        PORT_DATA    = 2'd0,
        PORT_STATUS  = 2'd1,
        PORT_MODE    = 2'd2,
        PORT_COMMAND = 2'd3
    } port_t;

    localparam logic FUNC_BUS  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // status bit positions
    localparam int ST_TBE = 0;
    localparam int ST_RDA = 1;
    localparam int ST_ORE = 4;
    localparam int ST_FME = 5;
    localparam int ST_DCD = 6;
    localparam int ST_DSR = 7;

    localparam logic [7:0] STATUS_RESET = 8'hC1;

    // command and interrupt mask bit positions
    localparam int CMD_TX_EN = 0;
    localparam int CMD_RX_EN = 2;
    localparam int IE_RX     = 4;
    localparam int IE_TX     = 5;

    localparam logic [7:0] VEC_RX    = 8'hE7;
    localparam logic [7:0] VEC_TX    = 8'hEF;
    localparam logic [7:0] RDATA_IDLE = 8'hFF;

    typedef struct packed {
        logic       force_dcd;
        logic [7:0] int_enable_mask;
        logic       int_ack_enable;
    } cfg_t;

    typedef struct packed {
        logic       func;
        port_t      port;
        logic       is_write;
        logic [7:0] wdata;
        logic       rx_valid;
        logic [7:0] rx_char;
        logic       dsr_in;
        logic       dcd_in;
        logic       tx_done;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_char;
        logic       irq;
        logic [7:0] irq_data;
        logic [2:0] baud_select;
        logic [1:0] stop_bits;
    } result_t;

    function automatic logic [2:0] baud_code(input logic [7:0] m2);
        logic [2:0] code;
        case (m2[3:0])
            4'h2:    code = 3'd0;
            4'h4:    code = 3'd1;
            4'h5:    code = 3'd2;
            4'h7:    code = 3'd3;
            4'hA:    code = 3'd4;
            4'hC:    code = 3'd5;
            default: code = 3'd6;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] stop_code(input logic [7:0] m1);
        return (m1[7:6] == 2'b11) ? 2'd2 : 2'd1;
    endfunction

endpackage

`default_nettype wire

>>> sv/urm_cfg.sv
// ----------------------------------------------------------------------------
// urm_cfg
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module urm_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [urm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [urm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output urm_pkg::cfg_t                       cfg
);
    import urm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FORCE_DCD: cfg_reg.force_dcd       <= cfg_wdata[0];
                CFG_INT_MASK:  cfg_reg.int_enable_mask <= cfg_wdata;
                CFG_INT_ACK:   cfg_reg.int_ack_enable  <= cfg_wdata[0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/urm_core.sv
// ----------------------------------------------------------------------------
// urm_core
// Register file of the UART: decodes one bus access or service tick, forms
// its result and updates the state when the beat advances.
// ----------------------------------------------------------------------------
`default_nettype none

module urm_core (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    advance,
    input  wire urm_pkg::item_t  item,
    input  wire urm_pkg::cfg_t   cfg,
    output urm_pkg::result_t res
);
    import urm_pkg::*;

    logic [7:0] status_reg,  status_next;
    logic [7:0] mode_one_reg, mode_one_next;
    logic [7:0] mode_two_reg, mode_two_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] rx_byte_reg, rx_byte_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       tx_pending_reg, tx_pending_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;

    logic       send;
    logic       rx_take;
    logic       irq_tx;
    logic       irq_rx;
    logic [7:0] rdata;

    always_comb begin
        status_next     = status_reg;
        mode_one_next   = mode_one_reg;
        mode_two_next   = mode_two_reg;
        command_next    = command_reg;
        rx_byte_next    = rx_byte_reg;
        tx_byte_next    = tx_byte_reg;
        tx_pending_next = tx_pending_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        rdata           = RDATA_IDLE;
        send            = 1'b0;
        rx_take         = 1'b0;

        if (item.func == FUNC_BUS) begin
            case (item.port)
                PORT_DATA: begin
                    if (item.is_write) begin
                        tx_byte_next        = item.wdata;
                        tx_pending_next     = 1'b1;
                        status_next[ST_TBE] = 1'b0;
                    end else begin
                        rdata               = rx_byte_reg;
                        status_next[ST_RDA] = 1'b0;
                        status_next[ST_FME] = 1'b0;
                        status_next[ST_ORE] = 1'b0;
                    end
                end
                PORT_STATUS: begin
                    if (!item.is_write) begin
                        rdata = status_reg;
                    end
                end
                PORT_MODE: begin
                    if (item.is_write) begin
                        if (wr_ptr_reg) begin
                            mode_two_next = item.wdata;
                        end else begin
                            mode_one_next = item.wdata;
                        end
                        wr_ptr_next = ~wr_ptr_reg;
                    end else begin
                        rdata       = rd_ptr_reg ? mode_two_reg : mode_one_reg;
                        rd_ptr_next = ~rd_ptr_reg;
                    end
                end
                default: begin
                    if (item.is_write) begin
                        command_next = item.wdata;
                    end else begin
                        rdata = command_reg;
                    end
                end
            endcase
        end else begin
            status_next[ST_DSR] = item.dsr_in;
            status_next[ST_DCD] = item.dcd_in | cfg.force_dcd;

            send = tx_pending_reg & command_reg[CMD_TX_EN];
            if (send) begin
                tx_pending_next = 1'b0;
            end

            if (!tx_pending_next && !status_reg[ST_TBE] && item.tx_done) begin
                status_next[ST_TBE] = 1'b1;
            end

            rx_take = !status_reg[ST_RDA] & command_reg[CMD_RX_EN] & item.rx_valid;
            if (rx_take) begin
                rx_byte_next        = item.rx_char;
                status_next[ST_RDA] = 1'b1;
                status_next[ST_FME] = 1'b0;
                status_next[ST_ORE] = 1'b0;
            end
        end
    end

    assign irq_tx = send & cfg.int_enable_mask[IE_TX] & cfg.int_ack_enable;
    assign irq_rx = rx_take & cfg.int_enable_mask[IE_RX] & cfg.int_ack_enable;

    always_comb begin
        res.rdata       = rdata;
        res.tx_valid    = send;
        res.tx_char     = send ? tx_byte_reg : 8'h00;
        res.irq         = irq_tx | irq_rx;
        res.irq_data    = irq_rx ? VEC_RX : (irq_tx ? VEC_TX : 8'h00);
        res.baud_select = baud_code(mode_two_next);
        res.stop_bits   = stop_code(mode_one_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= STATUS_RESET;
            mode_one_reg   <= '0;
            mode_two_reg   <= '0;
            command_reg    <= '0;
            rx_byte_reg    <= '0;
            tx_byte_reg    <= '0;
            tx_pending_reg <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            wr_ptr_reg     <= 1'b0;
        end else if (advance) begin
            status_reg     <= status_next;
            mode_one_reg   <= mode_one_next;
            mode_two_reg   <= mode_two_next;
            command_reg    <= command_next;
            rx_byte_reg    <= rx_byte_next;
            tx_byte_reg    <= tx_byte_next;
            tx_pending_reg <= tx_pending_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/urm_out_stage.sv
// ----------------------------------------------------------------------------
// urm_out_stage
// Result register of the master side: packs a result beat and holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module urm_out_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire urm_pkg::result_t               res,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [urm_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import urm_pkg::*;

    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= {1'b0, res.stop_bits, res.baud_select, res.irq_data,
                             res.irq, res.tx_char, res.tx_valid, res.rdata};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> sv/uart_register_model.sv
// ----------------------------------------------------------------------------
// uart_register_model
// 2651-style UART register block: data, status, mode and command ports
// reached by bus-access beats, plus service-tick beats from the line side.
//
// Slave channel s_*: one beat is one bus access (s_tuser = 0) or one service
// tick (s_tuser = 1). Master channel m_*: exactly one result beat per input
// beat, in order. Configuration writes on cfg_we/cfg_addr/cfg_wdata take
// effect at once. The user must make them with no beat in flight (unenforced).
//
// An input beat passes through an input register, then the register decode
// and state update feeding the result register. Throughput is one beat per
// cycle while m_tready is held high; the state of the register file is
// updated as a beat moves into the result register, so the next beat sees
// it right away.
//
// If the receiver holds m_tready low, the result register holds its beat; one
// more input beat is taken into the input register, then s_tready drops.
// Reset (aresetn low, synchronous) empties both stages and returns status to
// 0xC1, all other registers and mode pointers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_model (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // fields from bit 0: port[1:0], is_write, wdata[7:0], rx_valid,
    // rx_char[7:0], dsr_in, dcd_in, tx_done, zero fill
    input  wire logic [urm_pkg::IN_DATA_W-1:0]  s_tdata,
    // fields from bit 0: func
    input  wire logic [0:0]                     s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: rdata[7:0], tx_valid, tx_char[7:0], irq,
    // irq_data[7:0], baud_select[2:0], stop_bits[1:0], zero fill
    output logic [urm_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_we,
    input  wire logic [urm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [urm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import urm_pkg::*;

    `include "uart_register_model_assert.svh"

    logic    in_vld_reg;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    advance;
    cfg_t    cfg;
    result_t res;

    assign advance  = in_vld_reg & (~m_tvalid | m_tready);
    assign s_tready = ~in_vld_reg | advance;

    always_comb begin
        in_item_next.func     = s_tuser[0];
        in_item_next.port     = port_t'(s_tdata[1:0]);
        in_item_next.is_write = s_tdata[2];
        in_item_next.wdata    = s_tdata[10:3];
        in_item_next.rx_valid = s_tdata[11];
        in_item_next.rx_char  = s_tdata[19:12];
        in_item_next.dsr_in   = s_tdata[20];
        in_item_next.dcd_in   = s_tdata[21];
        in_item_next.tx_done  = s_tdata[22];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    urm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    urm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    urm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `URM_ASSERT_NEXT(a_bus_no_line, advance && (in_item_reg.func == FUNC_BUS), m_tvalid && !m_tdata[8] && !m_tdata[17], "bus access sent a character or raised irq")
    `URM_ASSERT_NEXT(a_tick_rdata, advance && (in_item_reg.func == FUNC_TICK), m_tvalid && (m_tdata[7:0] == RDATA_IDLE), "tick returned read data")
    `URM_ASSERT_IMP(a_tx_vector, m_tvalid && m_tdata[17] && (m_tdata[25:18] == VEC_TX), m_tdata[8], "transmit vector without a send")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the UART register block. Bus accesses and service
// ticks go in as input beats with random gaps. Each accepted beat runs through
// a local register model that yields the expected result beat. Every result
// beat is compared field by field, in order, under random output stalls.
// Configuration changes happen only once the block has drained.
// ----------------------------------------------------------------------------

module tb_top;
    import urm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_OPS      = 100;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    uart_register_model dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // register model state
    cfg_t       shadow_cfg;
    logic [7:0] status_q, mode_one_q, mode_two_q, command_q, rx_byte_q, tx_byte_q;
    logic       tx_pending_q, mode_rd_ptr, mode_wr_ptr;

    item_t   pending_ops[$];
    result_t reply_q[$];
    item_t   cur_op;

    int errors     = 0;
    int n_ops      = 0;
    int n_ticks    = 0;
    int n_replies  = 0;
    int n_sends    = 0;
    int n_irqs     = 0;
    int n_settings = 0;
    int src_gap    = 0;
    int rdy_gap    = 0;
    int idle_cnt   = 0;
    bit src_burst  = 1'b0;
    bit rdy_burst  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic result_t step_uart(input item_t op);
        result_t r;
        r = '0;
        r.rdata = RDATA_IDLE;
        if (op.func == FUNC_BUS) begin
            case (op.port)
                PORT_DATA: begin
                    if (op.is_write) begin
                        tx_byte_q        = op.wdata;
                        tx_pending_q     = 1'b1;
                        status_q[ST_TBE] = 1'b0;
                    end else begin
                        r.rdata          = rx_byte_q;
                        status_q[ST_RDA] = 1'b0;
                        status_q[ST_FME] = 1'b0;
                        status_q[ST_ORE] = 1'b0;
                    end
                end
                PORT_STATUS: begin
                    if (!op.is_write)
                        r.rdata = status_q;
                end
                PORT_MODE: begin
                    if (op.is_write) begin
                        if (mode_wr_ptr)
                            mode_two_q = op.wdata;
                        else
                            mode_one_q = op.wdata;
                        mode_wr_ptr = ~mode_wr_ptr;
                    end else begin
                        r.rdata     = mode_rd_ptr ? mode_two_q : mode_one_q;
                        mode_rd_ptr = ~mode_rd_ptr;
                    end
                end
                default: begin
                    if (op.is_write)
                        command_q = op.wdata;
                    else
                        r.rdata = command_q;
                end
            endcase
        end else begin
            status_q[ST_DSR] = op.dsr_in;
            status_q[ST_DCD] = op.dcd_in | shadow_cfg.force_dcd;
            if (tx_pending_q && command_q[CMD_TX_EN]) begin
                r.tx_valid   = 1'b1;
                r.tx_char    = tx_byte_q;
                tx_pending_q = 1'b0;
                if (shadow_cfg.int_enable_mask[IE_TX] && shadow_cfg.int_ack_enable) begin
                    r.irq      = 1'b1;
                    r.irq_data = VEC_TX;
                end
            end
            if (!tx_pending_q && !status_q[ST_TBE] && op.tx_done)
                status_q[ST_TBE] = 1'b1;
            if (!status_q[ST_RDA] && command_q[CMD_RX_EN] && op.rx_valid) begin
                rx_byte_q        = op.rx_char;
                status_q[ST_RDA] = 1'b1;
                status_q[ST_FME] = 1'b0;
                status_q[ST_ORE] = 1'b0;
                // receive request wins when both fire
                if (shadow_cfg.int_enable_mask[IE_RX] && shadow_cfg.int_ack_enable) begin
                    r.irq      = 1'b1;
                    r.irq_data = VEC_RX;
                end
            end
        end
        case (mode_two_q[3:0])
            4'h2:    r.baud_select = 3'd0;
            4'h4:    r.baud_select = 3'd1;
            4'h5:    r.baud_select = 3'd2;
            4'h7:    r.baud_select = 3'd3;
            4'hA:    r.baud_select = 3'd4;
            4'hC:    r.baud_select = 3'd5;
            default: r.baud_select = 3'd6;
        endcase
        r.stop_bits = (mode_one_q[7:6] == 2'b11) ? 2'd2 : 2'd1;
        return r;
    endfunction

    // unused fields of each kind are randomized so every bit toggles
    function automatic item_t bus_op(input port_t p, input logic wr, input logic [7:0] d);
        item_t op;
        op          = item_t'({$urandom, $urandom});
        op.func     = FUNC_BUS;
        op.port     = p;
        op.is_write = wr;
        op.wdata    = d;
        return op;
    endfunction

    function automatic item_t tick_op(input logic rxv, input logic [7:0] rxc,
                                      input logic dsr, input logic dcd, input logic done);
        item_t op;
        op          = item_t'({$urandom, $urandom});
        op.func     = FUNC_TICK;
        op.rx_valid = rxv;
        op.rx_char  = rxc;
        op.dsr_in   = dsr;
        op.dcd_in   = dcd;
        op.tx_done  = done;
        return op;
    endfunction

    function automatic item_t random_op();
        int         r;
        logic [7:0] d;
        r = $urandom_range(0, 99);
        d = 8'($urandom);
        if (r < 38)
            return tick_op($urandom_range(0, 3) != 0, 8'($urandom), 1'($urandom),
                           1'($urandom), $urandom_range(0, 2) != 0);
        if (r < 53)
            return bus_op(PORT_DATA, 1'b1, d);
        if (r < 66)
            return bus_op(PORT_DATA, 1'b0, d);
        if (r < 75)
            return bus_op(PORT_STATUS, 1'b0, d);
        if (r < 78)
            return bus_op(PORT_STATUS, 1'b1, d);
        if (r < 88)
            return bus_op(PORT_MODE, 1'($urandom), d);
        if (r < 95) begin
            // mostly keep both transmitter and receiver on
            if ($urandom_range(0, 4) != 0)
                d = d | 8'h05;
            return bus_op(PORT_COMMAND, 1'b1, d);
        end
        return bus_op(PORT_COMMAND, 1'b0, d);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_cfg(input cfg_t c);
        write_reg(CFG_FORCE_DCD, {7'd0, c.force_dcd});
        write_reg(CFG_INT_MASK, c.int_enable_mask);
        write_reg(CFG_INT_ACK, {7'd0, c.int_ack_enable});
        shadow_cfg = c;
        n_settings++;
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || reply_q.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_q.push_back(step_uart(cur_op));
                n_ops++;
                if (cur_op.func == FUNC_TICK)
                    n_ticks++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    cur_op   = pending_ops.pop_front();
                    s_tdata  <= {1'b0, cur_op.tx_done, cur_op.dcd_in, cur_op.dsr_in,
                                 cur_op.rx_char, cur_op.rx_valid, cur_op.wdata,
                                 cur_op.is_write, cur_op.port};
                    s_tuser  <= cur_op.func;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        src_burst = !src_burst;
                    src_gap = pick_gap(src_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("result beat with nothing expected: 0x%08h", m_tdata);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("rdata", want.rdata, m_tdata[7:0]);
                    check_field("tx_valid", 8'(want.tx_valid), 8'(m_tdata[8]));
                    check_field("tx_char", want.tx_char, m_tdata[16:9]);
                    check_field("irq", 8'(want.irq), 8'(m_tdata[17]));
                    check_field("irq_data", want.irq_data, m_tdata[25:18]);
                    check_field("baud_select", 8'(want.baud_select), 8'(m_tdata[28:26]));
                    check_field("stop_bits", 8'(want.stop_bits), 8'(m_tdata[30:29]));
                    n_replies++;
                    n_sends += int'(m_tdata[8]);
                    n_irqs  += int'(m_tdata[17]);
                end
            end
            if (rdy_gap > 0) begin
                rdy_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    rdy_burst = !rdy_burst;
                if ($urandom_range(0, 2) == 0)
                    rdy_gap = pick_gap(rdy_burst);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", reply_q.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        cfg_t c;
        shadow_cfg   = '0;
        status_q     = STATUS_RESET;
        mode_one_q   = '0;
        mode_two_q   = '0;
        command_q    = '0;
        rx_byte_q    = '0;
        tx_byte_q    = '0;
        tx_pending_q = 1'b0;
        mode_rd_ptr  = 1'b0;
        mode_wr_ptr  = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        apply_cfg('{force_dcd: 1'b0, int_enable_mask: 8'h30, int_ack_enable: 1'b1});
        @(negedge aclk);
        pending_ops.push_back(bus_op(PORT_STATUS, 1'b0, 8'h00));
        pending_ops.push_back(bus_op(PORT_MODE, 1'b0, 8'h00));
        pending_ops.push_back(bus_op(PORT_MODE, 1'b0, 8'hFF));
        pending_ops.push_back(bus_op(PORT_COMMAND, 1'b0, 8'h00));
        pending_ops.push_back(bus_op(PORT_DATA, 1'b0, 8'hFF));
        pending_ops.push_back(bus_op(PORT_STATUS, 1'b1, 8'hFF));
        pending_ops.push_back(bus_op(PORT_MODE, 1'b1, 8'hC0));
        pending_ops.push_back(bus_op(PORT_MODE, 1'b1, 8'h0A));
        pending_ops.push_back(bus_op(PORT_MODE, 1'b0, 8'h00));
        pending_ops.push_back(bus_op(PORT_MODE, 1'b1, 8'hFF));
        pending_ops.push_back(bus_op(PORT_COMMAND, 1'b1, 8'h05));
        pending_ops.push_back(bus_op(PORT_DATA, 1'b1, 8'h00));
        pending_ops.push_back(bus_op(PORT_DATA, 1'b1, 8'hFF));
        // send, line done and receive all in one tick
        pending_ops.push_back(tick_op(1'b1, 8'hFF, 1'b0, 1'b0, 1'b1));
        // drop: receive buffer full
        pending_ops.push_back(tick_op(1'b1, 8'h00, 1'b1, 1'b1, 1'b0));
        pending_ops.push_back(bus_op(PORT_STATUS, 1'b0, 8'h00));
        pending_ops.push_back(bus_op(PORT_DATA, 1'b0, 8'h00));
        pending_ops.push_back(bus_op(PORT_COMMAND, 1'b1, 8'h00));
        // drop: receiver off
        pending_ops.push_back(tick_op(1'b1, 8'h55, 1'b1, 1'b0, 1'b1));
        pending_ops.push_back(bus_op(PORT_DATA, 1'b1, 8'h3C));
        pending_ops.push_back(tick_op(1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
        pending_ops.push_back(bus_op(PORT_COMMAND, 1'b1, 8'h01));
        pending_ops.push_back(tick_op(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
        pending_ops.push_back(tick_op(1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
        pending_ops.push_back(bus_op(PORT_MODE, 1'b0, 8'h00));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: c = '{force_dcd: 1'b0, int_enable_mask: 8'h00, int_ack_enable: 1'b0};
                1: c = '{force_dcd: 1'b1, int_enable_mask: 8'hFF, int_ack_enable: 1'b1};
                2: c = '{force_dcd: 1'b0, int_enable_mask: 8'h10, int_ack_enable: 1'b1};
                3: c = '{force_dcd: 1'b1, int_enable_mask: 8'h20, int_ack_enable: 1'b1};
                4: c = '{force_dcd: 1'b0, int_enable_mask: 8'hFF, int_ack_enable: 1'b0};
                default: c = cfg_t'($urandom);
            endcase
            apply_cfg(c);
            @(negedge aclk);
            for (int i = 0; i < PHASE_OPS; i++)
                pending_ops.push_back(random_op());
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (reply_q.size() != 0) begin
            $error("%0d expected results never arrived", reply_q.size());
            errors++;
        end
        $display("covered %0d input beats (%0d ticks) over %0d settings",
                 n_ops, n_ticks, n_settings);
        $display("checked %0d result beats: %0d line sends, %0d interrupts",
                 n_replies, n_sends, n_irqs);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/urm_pkg.sv
sv/urm_cfg.sv
sv/urm_core.sv
sv/urm_out_stage.sv
sv/uart_register_model.sv
bench/tb_top.sv
